// ===== hdl/kpe_pkg.sv =====
// ----------------------------------------------------------------------------
// kpe_pkg
// Shared types and constants for the multi-tap keypad encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package kpe_pkg;

    // ASCII symbols used by the encoder
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_ONE    = 8'h31;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [7:0] CHAR_LO_A   = 8'h61;
    localparam logic [7:0] CHAR_LO_Z   = 8'h7A;

    // Key value held after reset and after a space
    localparam logic [3:0] KEY_RESET = 4'd1;
    localparam logic [3:0] KEY_SPACE = 4'd0;

    localparam int LETTER_COUNT = 26;

    // Command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_INVALID,
        CMD_SPACE,
        CMD_LETTER
    } cmd_kind_t;

    // Symbol that leads a letter's taps
    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_ONE,
        PFX_HASH
    } prefix_t;

    typedef struct packed {
        logic [3:0] key;
        logic [2:0] taps;
    } key_taps_t;

    typedef struct packed {
        cmd_kind_t  kind;
        prefix_t    prefix;
        logic [3:0] key;
        logic [2:0] taps;
    } kpe_cmd_t;

    // Key and tap count for letters a..z
    localparam key_taps_t LETTER_TABLE [LETTER_COUNT] = '{
        '{4'd2, 3'd1}, '{4'd2, 3'd2}, '{4'd2, 3'd3},
        '{4'd3, 3'd1}, '{4'd3, 3'd2}, '{4'd3, 3'd3},
        '{4'd4, 3'd1}, '{4'd4, 3'd2}, '{4'd4, 3'd3},
        '{4'd5, 3'd1}, '{4'd5, 3'd2}, '{4'd5, 3'd3},
        '{4'd6, 3'd1}, '{4'd6, 3'd2}, '{4'd6, 3'd3},
        '{4'd7, 3'd1}, '{4'd7, 3'd2}, '{4'd7, 3'd3}, '{4'd7, 3'd4},
        '{4'd8, 3'd1}, '{4'd8, 3'd2}, '{4'd8, 3'd3},
        '{4'd9, 3'd1}, '{4'd9, 3'd2}, '{4'd9, 3'd3}, '{4'd9, 3'd4}
    };

    // Back-end sequencer states
    typedef enum logic {
        EM_HEAD,
        EM_TAPS
    } emit_state_t;

endpackage

`default_nettype wire

// ===== hdl/kpe_front.sv =====
// ----------------------------------------------------------------------------
// kpe_front
// Accepts input characters, classifies them and tracks the previous key.
// ----------------------------------------------------------------------------
`default_nettype none

module kpe_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       in_char,
    output logic                  q_push,
    output kpe_pkg::kpe_cmd_t     q_cmd,
    input  wire logic             q_full
);

    logic [3:0]          prev_key_reg;
    logic [3:0]          prev_key_next;
    logic                is_space;
    logic                is_upper;
    logic                is_lower;
    logic [7:0]          offset;
    logic [4:0]          idx;
    kpe_pkg::key_taps_t  entry;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Character class
    assign is_space = (in_char == kpe_pkg::CHAR_SPACE);
    assign is_upper = (in_char >= kpe_pkg::CHAR_UP_A) && (in_char <= kpe_pkg::CHAR_UP_Z);
    assign is_lower = (in_char >= kpe_pkg::CHAR_LO_A) && (in_char <= kpe_pkg::CHAR_LO_Z);

    // Letter index 0..25
    assign offset = is_upper ? (in_char - kpe_pkg::CHAR_UP_A) : (in_char - kpe_pkg::CHAR_LO_A);
    assign idx    = offset[4:0];
    assign entry  = kpe_pkg::LETTER_TABLE[idx];

    // Command build and key tracking
    always_comb
    begin
        q_cmd.kind    = kpe_pkg::CMD_INVALID;
        q_cmd.prefix  = kpe_pkg::PFX_NONE;
        q_cmd.key     = entry.key;
        q_cmd.taps    = entry.taps;
        prev_key_next = prev_key_reg;
        priority if (is_space)
        begin
            q_cmd.kind    = kpe_pkg::CMD_SPACE;
            prev_key_next = kpe_pkg::KEY_SPACE;
        end
        else if (is_upper || is_lower)
        begin
            q_cmd.kind    = kpe_pkg::CMD_LETTER;
            prev_key_next = entry.key;
            if (is_upper)
            begin
                q_cmd.prefix = kpe_pkg::PFX_ONE;
            end
            else if (entry.key == prev_key_reg)
            begin
                q_cmd.prefix = kpe_pkg::PFX_HASH;
            end
        end
        else
        begin
            q_cmd.kind = kpe_pkg::CMD_INVALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_key_reg <= kpe_pkg::KEY_RESET;
        end
        else if (q_push)
        begin
            prev_key_reg <= prev_key_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/kpe_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// kpe_cmd_fifo
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module kpe_cmd_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire kpe_pkg::kpe_cmd_t push_cmd,
    output logic                   full,
    input  wire logic              pop,
    output kpe_pkg::kpe_cmd_t      head_cmd,
    output logic                   head_valid
);

    kpe_pkg::kpe_cmd_t slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/kpe_emit.sv =====
// ----------------------------------------------------------------------------
// kpe_emit
// Back end: expands a command into symbols, one per cycle if not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module kpe_emit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire kpe_pkg::kpe_cmd_t cmd,
    input  wire logic              cmd_valid,
    output logic                   cmd_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_char,
    output logic                   last,
    output logic                   invalid
);

    kpe_pkg::emit_state_t state_reg;
    kpe_pkg::emit_state_t state_next;
    logic [2:0]           tap_cnt_reg;
    logic [2:0]           tap_cnt_next;
    logic                 out_valid_reg;
    logic [7:0]           out_char_reg;
    logic                 last_reg;
    logic                 invalid_reg;
    logic                 load;
    logic [7:0]           sym_char;
    logic                 sym_last;
    logic                 sym_invalid;

    // Output slot is free or being drained
    assign load = cmd_valid && (!out_valid_reg || out_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        if (load)
        begin
            if ((cmd.kind == kpe_pkg::CMD_LETTER) && !sym_last)
            begin
                state_next = kpe_pkg::EM_TAPS;
            end
            else
            begin
                state_next = kpe_pkg::EM_HEAD;
            end
        end
    end

    // Symbol selection, tap count, queue pop
    always_comb
    begin
        sym_char     = kpe_pkg::CHAR_ZERO;
        sym_last     = 1'b1;
        sym_invalid  = 1'b0;
        tap_cnt_next = tap_cnt_reg;
        cmd_pop      = 1'b0;
        unique case (cmd.kind)
            kpe_pkg::CMD_SPACE:
            begin
                sym_char = kpe_pkg::CHAR_ZERO;
                cmd_pop  = load;
            end
            kpe_pkg::CMD_LETTER:
            begin
                if ((state_reg == kpe_pkg::EM_HEAD) && (cmd.prefix != kpe_pkg::PFX_NONE))
                begin
                    sym_char = (cmd.prefix == kpe_pkg::PFX_ONE) ? kpe_pkg::CHAR_ONE
                                                                 : kpe_pkg::CHAR_HASH;
                    sym_last = 1'b0;
                end
                else
                begin
                    sym_char = kpe_pkg::CHAR_ZERO + {4'd0, cmd.key};
                    sym_last = (tap_cnt_reg == (cmd.taps - 3'd1));
                    if (load)
                    begin
                        cmd_pop      = sym_last;
                        tap_cnt_next = sym_last ? 3'd0 : (tap_cnt_reg + 3'd1);
                    end
                end
            end
            default:
            begin
                sym_char    = 8'd0;
                sym_invalid = 1'b1;
                cmd_pop     = load;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kpe_pkg::EM_HEAD;
            tap_cnt_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tap_cnt_reg <= tap_cnt_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output symbol register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= sym_char;
            last_reg     <= sym_last;
            invalid_reg  <= sym_invalid;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;
    assign invalid   = invalid_reg;

endmodule

`default_nettype wire

// ===== hdl/multitap_keypad_encoder.sv =====
// ----------------------------------------------------------------------------
// multitap_keypad_encoder
// Turns ASCII text into phone-keypad multi-tap code, one symbol per transfer.
// ----------------------------------------------------------------------------
// Each input character gives one to five output symbols ('0'..'9', '#', or a
// zero byte flagged invalid), the final one marked by last. The output symbol
// register produces one symbol per cycle unless out_ready holds it back: one
// symbol for a space or a non-letter, up to five for an uppercase s or z, or
// for an s or z that repeats the previous key.
// A two-entry command queue lets the input side take up to two characters
// ahead of the symbols still being sent. The
// repeat-key '#' is decided against the key of the last accepted letter
// (reset value 1, 0 after a space); non-letters leave that key unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module multitap_keypad_encoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_char,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_char,
    output logic            last,
    output logic            invalid
);

    kpe_pkg::kpe_cmd_t q_cmd;
    kpe_pkg::kpe_cmd_t head_cmd;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              head_valid;

    kpe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_char  (in_char),
        .q_push   (q_push),
        .q_cmd    (q_cmd),
        .q_full   (q_full)
    );

    kpe_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid)
    );

    kpe_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (head_valid),
        .cmd_pop   (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last),
        .invalid   (invalid)
    );

    // An invalid result is always the only and final one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid |-> last)
    else $error("invalid result not marked last");

    // A prefix symbol never ends a character
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_char == kpe_pkg::CHAR_HASH || out_char == kpe_pkg::CHAR_ONE)
        |-> !last)
    else $error("prefix symbol marked last");

    // After a non-final symbol, the rest of the character follows without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |=> out_valid)
    else $error("gap inside a character's symbols");

    // Queue is popped only when it holds a command
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> head_valid)
    else $error("command queue underflow");

endmodule

`default_nettype wire

// ===== bench/multitap_keypad_encoder_checker.sv =====
// ----------------------------------------------------------------------------
// multitap_keypad_encoder_checker
// Watches both channels of the keypad encoder and checks every output symbol.
// ----------------------------------------------------------------------------
// Every input transfer is run through a local multi-tap encoder. That encoder
// keeps its own copy of the previous key. The symbols it produces are queued
// in order. Every output transfer is compared field by field with the oldest
// queued symbol. The number of failures and the number of symbols still owed
// are passed up to the bench top.
// ----------------------------------------------------------------------------
module multitap_keypad_encoder_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_char,
    input  logic       last,
    input  logic       invalid,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CASE_OFFSET = kpe_pkg::CHAR_LO_A - kpe_pkg::CHAR_UP_A;
    localparam logic [7:0] CHAR_LO_S   = kpe_pkg::CHAR_LO_A + 8'd18;
    localparam logic [7:0] NO_SYMBOL   = 8'h00;
    localparam int         REPORT_MAX  = 10;

    typedef struct packed {
        logic [7:0] sym;
        logic       is_last;
        logic       bad;
    } keypad_sym_t;

    keypad_sym_t code_q[$];
    keypad_sym_t want;
    logic [3:0]  prev_key = kpe_pkg::KEY_RESET;

    function automatic void add_symbol(input logic [7:0] sym, input logic is_last,
                                       input logic bad);
        keypad_sym_t s;
        s.sym     = sym;
        s.is_last = is_last;
        s.bad     = bad;
        code_q.push_back(s);
    endfunction

    // Queue the multi-tap code of one character and advance the key state
    function automatic void push_multitap_code(input logic [7:0] c);
        logic       upper;
        logic [7:0] lc;
        logic [4:0] idx;
        logic [3:0] key;
        logic [2:0] taps;
        int         i;
        upper = (c >= kpe_pkg::CHAR_UP_A) && (c <= kpe_pkg::CHAR_UP_Z);
        lc    = upper ? c + CASE_OFFSET : c;
        if (c == kpe_pkg::CHAR_SPACE)
        begin
            add_symbol(kpe_pkg::CHAR_ZERO, 1'b1, 1'b0);
            prev_key = kpe_pkg::KEY_SPACE;
        end
        else if (lc < kpe_pkg::CHAR_LO_A || lc > kpe_pkg::CHAR_LO_Z)
        begin
            // not a letter: flagged, key state kept
            add_symbol(NO_SYMBOL, 1'b1, 1'b1);
        end
        else
        begin
            idx = 5'(lc - kpe_pkg::CHAR_LO_A);
            // s and z are the fourth letters on keys 7 and 9
            if (lc == CHAR_LO_S)
            begin
                key  = 4'd7;
                taps = 3'd4;
            end
            else if (lc == kpe_pkg::CHAR_LO_Z)
            begin
                key  = 4'd9;
                taps = 3'd4;
            end
            else
            begin
                if (lc > CHAR_LO_S)
                    idx = idx - 5'd1;
                key  = 4'(idx / 5'd3 + 5'd2);
                taps = 3'(idx % 5'd3 + 5'd1);
            end
            // uppercase mark wins over the repeat-key separator
            if (upper)
                add_symbol(kpe_pkg::CHAR_ONE, 1'b0, 1'b0);
            else if (key == prev_key)
                add_symbol(kpe_pkg::CHAR_HASH, 1'b0, 1'b0);
            for (i = 0; i < taps; i++)
                add_symbol(kpe_pkg::CHAR_ZERO + key, i == taps - 1, 1'b0);
            prev_key = key;
        end
    endfunction

    // Compare output transfers first, then queue the code of an input transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_q.delete();
            prev_key   = kpe_pkg::KEY_RESET;
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (code_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: unexpected symbol char %h last %b invalid %b",
                                 $realtime, out_char, last, invalid);
                end
                else
                begin
                    want = code_q.pop_front();
                    if (out_char !== want.sym || last !== want.is_last ||
                        invalid !== want.bad)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display({"%0t: symbol mismatch: expected char %h last %b ",
                                      "invalid %b, got char %h last %b invalid %b"},
                                     $realtime, want.sym, want.is_last, want.bad,
                                     out_char, last, invalid);
                    end
                end
            end
            if (in_valid && in_ready)
                push_multitap_code(in_char);
            pending = code_q.size();
        end
    end

endmodule

// ===== bench/multitap_keypad_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// multitap_keypad_encoder_tb
// Stimulus and verdict for the multi-tap keypad encoder.
// ----------------------------------------------------------------------------
// A directed run covers byte extremes, the borders of the letter ranges,
// uppercase, space, the repeat-key separator, and bytes that are not letters.
// It is followed by random text: mostly letters, spaces and repeated keys,
// mixed with arbitrary bytes. Both channels idle at random, with one burst
// that has no idling. In the middle the sender waits until the output has
// drained. All checking is done by the checker module.
// ----------------------------------------------------------------------------
module multitap_keypad_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 20;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_char = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_char;
    logic       last;
    logic       invalid;
    int         fail_count;
    int         pending;
    logic       no_idle = 1'b0;
    logic [7:0] last_lower = kpe_pkg::CHAR_LO_A;

    multitap_keypad_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_char   (in_char),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last),
        .invalid   (invalid)
    );

    multitap_keypad_encoder_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_char    (in_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .last       (last),
        .invalid    (invalid),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // One input transfer; starts and ends on a falling edge
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Random text, weighted toward letters and key repeats
    task automatic run_text(input int count);
        int         k;
        int         r;
        logic [7:0] c;
        for (k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                c = kpe_pkg::CHAR_LO_A + 8'($urandom_range(0, kpe_pkg::LETTER_COUNT - 1));
            else if (r < 65)
                c = kpe_pkg::CHAR_UP_A + 8'($urandom_range(0, kpe_pkg::LETTER_COUNT - 1));
            else if (r < 77)
                c = kpe_pkg::CHAR_SPACE;
            else if (r < 88)
                c = last_lower;
            else
                c = 8'($urandom_range(0, 255));
            if (c >= kpe_pkg::CHAR_LO_A && c <= kpe_pkg::CHAR_LO_Z)
                last_lower = c;
            send_char(c);
        end
    endtask

    // Output ready: random runs high and low
    initial
    begin
        int   hold_n;
        int   r;
        logic level;
        hold_n = 0;
        level  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_n == 0)
            begin
                r = $urandom_range(0, 99);
                if (no_idle || r < 60)
                begin
                    level  = 1'b1;
                    hold_n = $urandom_range(1, 8);
                end
                else if (r < 95)
                begin
                    level  = 1'b0;
                    hold_n = $urandom_range(1, 3);
                end
                else
                begin
                    level  = 1'b0;
                    hold_n = $urandom_range(10, 40);
                end
            end
            hold_n--;
            out_ready <= level;
        end
    end

    // Main sequence
    initial
    begin
        logic [7:0] directed [25];
        int         k;
        directed = '{8'h00, 8'hFF, 8'h80,
                     kpe_pkg::CHAR_UP_A - 8'd1, kpe_pkg::CHAR_UP_Z + 8'd1,
                     kpe_pkg::CHAR_LO_A - 8'd1, kpe_pkg::CHAR_LO_Z + 8'd1,
                     "a", "b", "!", "c", "A", "s", "S", "z", "Z", "w",
                     kpe_pkg::CHAR_SPACE, "w", kpe_pkg::CHAR_SPACE, kpe_pkg::CHAR_SPACE,
                     "t", "u", "m", "Y"};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, range borders, uppercase, repeats, spaces
        for (k = 0; k < 25; k++)
            send_char(directed[k]);

        run_text(110);

        // hold off until every owed symbol is out
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);

        // burst with no idling on either side
        no_idle <= 1'b1;
        run_text(40);
        no_idle <= 1'b0;

        run_text(85);
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("multitap_keypad_encoder_tb OK");
        else
            $display("multitap_keypad_encoder_tb NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("multitap_keypad_encoder_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/kpe_pkg.sv
hdl/kpe_front.sv
hdl/kpe_cmd_fifo.sv
hdl/kpe_emit.sv
hdl/multitap_keypad_encoder.sv
bench/multitap_keypad_encoder_checker.sv
bench/multitap_keypad_encoder_tb.sv
